@@ hdl/stereo_to_five_channel_upmix_fir_core_macros.svh @@
// Assertion macros for the stereo upmix FIR core.
`ifndef STEREO_TO_FIVE_CHANNEL_UPMIX_FIR_CORE_MACROS_SVH
`define STEREO_TO_FIVE_CHANNEL_UPMIX_FIR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// checked only out of reset; expects clk and rst_n in scope
`define UPMIX_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// checked at every rising clock edge, also during reset
`define UPMIX_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define UPMIX_ASSERT(lbl, prop, msg)
`define UPMIX_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/upmix_pkg.sv @@
// Shared constants, command type and coefficient table for the upmix core.
package upmix_pkg;

  localparam int TAPS        = 31;
  localparam int CHANNELS    = 5;
  localparam int SAMPLE_BITS = 24;
  localparam int GAIN_BITS   = 16;
  localparam int GAIN_FRAC   = 12;
  localparam int COEF_FRAC   = 23;
  localparam int COEF_BITS   = 24;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int MIX_ACC_BITS = 41;
  localparam int FIR_ACC_BITS = 53;
  localparam int SAT_LIM     = 8380219;

  localparam int HIST_DEPTH = TAPS * CHANNELS;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int TAP_W      = $clog2(TAPS);
  localparam int CH_W       = $clog2(CHANNELS);
  localparam int CYC_W      = $clog2(TAPS + 5);

  localparam int REG_W      = 32;
  localparam int ADDR_W     = 5;
  localparam int REG_IDX_W  = 3;
  localparam logic [REG_W-1:0] GAIN_RESET = 32'h195C0A18;

  localparam logic [REG_IDX_W-1:0] REG_GAINS_FL  = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAINS_FR  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAINS_SL  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GAINS_SR  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_GAINS_C   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FILTER_EN = 3'd5;

  localparam logic [CH_W-1:0] CH_FL = 3'd0;
  localparam logic [CH_W-1:0] CH_FR = 3'd1;
  localparam logic [CH_W-1:0] CH_SL = 3'd2;
  localparam logic [CH_W-1:0] CH_SR = 3'd3;
  localparam logic [CH_W-1:0] CH_C  = 3'd4;

  localparam int OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE      = 3'd0;
  localparam logic [OP_W-1:0] OP_MIX_L     = 3'd1;
  localparam logic [OP_W-1:0] OP_MIX_R     = 3'd2;
  localparam logic [OP_W-1:0] OP_TAP_FIRST = 3'd3;
  localparam logic [OP_W-1:0] OP_TAP       = 3'd4;
  localparam logic [OP_W-1:0] OP_TAP_Y     = 3'd5;

  typedef logic [CHANNELS-1:0][REG_W-1:0] gain_bank_t;
  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] chan_vec_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [TAP_W-1:0]   tap;
    logic [CH_W-1:0]    ch;
    logic [HIST_AW-1:0] raddr;
    logic               we;
    logic [HIST_AW-1:0] waddr;
    logic               wr_zero;
    logic               ld_in;
    logic               ld_out;
  } upmix_cmd_t;

  function automatic logic signed [COEF_BITS-1:0] coef(input logic [TAP_W-1:0] idx);
    case (idx)
      5'd0:    coef = -24'sd2714;
      5'd1:    coef = 24'sd5150;
      5'd2:    coef = -24'sd8252;
      5'd3:    coef = 24'sd11408;
      5'd4:    coef = -24'sd13179;
      5'd5:    coef = 24'sd10860;
      5'd6:    coef = -24'sd22;
      5'd7:    coef = -24'sd25835;
      5'd8:    coef = 24'sd75265;
      5'd9:    coef = -24'sd158123;
      5'd10:   coef = 24'sd283572;
      5'd11:   coef = -24'sd456275;
      5'd12:   coef = 24'sd670256;
      5'd13:   coef = -24'sd900217;
      5'd14:   coef = 24'sd1090801;
      5'd15:   coef = 24'sd7223215;
      5'd16:   coef = 24'sd1090801;
      5'd17:   coef = -24'sd900217;
      5'd18:   coef = 24'sd670256;
      5'd19:   coef = -24'sd456275;
      5'd20:   coef = 24'sd283572;
      5'd21:   coef = -24'sd158123;
      5'd22:   coef = 24'sd75265;
      5'd23:   coef = -24'sd25835;
      5'd24:   coef = -24'sd22;
      5'd25:   coef = 24'sd10860;
      5'd26:   coef = -24'sd13179;
      5'd27:   coef = 24'sd11408;
      5'd28:   coef = -24'sd8252;
      5'd29:   coef = 24'sd5150;
      5'd30:   coef = -24'sd2714;
      default: coef = '0;
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] sat(input logic signed [FIR_ACC_BITS-1:0] v);
    logic signed [FIR_ACC_BITS-1:0] c;
    c = v;
    if (v > SAT_LIM) begin
      c = FIR_ACC_BITS'(SAT_LIM);
    end else if (v < -SAT_LIM) begin
      c = -FIR_ACC_BITS'(SAT_LIM);
    end
    sat = c[SAMPLE_BITS-1:0];
  endfunction

endpackage

@@ hdl/upmix_ram.sv @@
// Generic simple dual-port RAM with registered read.
module upmix_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/upmix_ctrl.sv @@
// Sequencer for history clear, per-channel mix and FIR passes, and output handoff.
`include "stereo_to_five_channel_upmix_fir_core_macros.svh"

module upmix_ctrl
  import upmix_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       out_stall,
  input  logic       filter_en,
  output logic       in_stall,
  output logic       out_valid,
  output upmix_cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RUN   = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  localparam logic [CYC_W-1:0] CYC_MIX_R    = CYC_W'(1);
  localparam logic [CYC_W-1:0] CYC_TAP0     = CYC_W'(2);
  localparam logic [CYC_W-1:0] CYC_TAP_LAST = CYC_W'(TAPS);
  localparam logic [CYC_W-1:0] CYC_TAP_Y    = CYC_W'(TAPS + 1);
  localparam logic [CYC_W-1:0] CYC_END_FIR  = CYC_W'(TAPS + 4);
  localparam logic [CYC_W-1:0] CYC_END_MIX  = CYC_W'(4);

  logic [1:0]         state_r, state_nxt;
  logic [HIST_AW-1:0] clr_r, clr_nxt;
  logic [CH_W-1:0]    ch_r, ch_nxt;
  logic [CYC_W-1:0]   cyc_r, cyc_nxt;
  logic [HIST_AW-1:0] base_r, base_nxt;
  logic [TAP_W-1:0]   pos_r, pos_nxt;
  logic [TAP_W-1:0]   wp_r, wp_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [TAP_W-1:0]   wp_next;
  logic [CYC_W-1:0]   cyc_end;

  assign wp_next   = (wp_r == TAP_W'(TAPS - 1)) ? '0 : wp_r + TAP_W'(1);
  assign cyc_end   = filter_en ? CYC_END_FIR : CYC_END_MIX;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    ch_nxt        = ch_r;
    cyc_nxt       = cyc_r;
    base_nxt      = base_r;
    pos_nxt       = pos_r;
    wp_nxt        = wp_r;
    out_valid_nxt = out_valid_r & out_stall;
    cmd           = '0;
    cmd.op        = OP_NONE;
    cmd.ch        = ch_r;
    cmd.raddr     = base_r + HIST_AW'(pos_r);
    cmd.waddr     = base_r + HIST_AW'(wp_r);

    case (state_r)
      ST_CLEAR: begin
        cmd.we      = 1'b1;
        cmd.wr_zero = 1'b1;
        cmd.waddr   = clr_r;
        if (clr_r == HIST_AW'(HIST_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + HIST_AW'(1);
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = ST_RUN;
          ch_nxt    = '0;
          cyc_nxt   = '0;
          base_nxt  = '0;
          pos_nxt   = wp_next;
        end
      end
      ST_RUN: begin
        if (cyc_r == '0) begin
          cmd.op = OP_MIX_L;
        end else if (cyc_r == CYC_MIX_R) begin
          cmd.op = OP_MIX_R;
        end else if (filter_en && cyc_r >= CYC_TAP0 && cyc_r <= CYC_TAP_LAST) begin
          cmd.op  = (cyc_r == CYC_TAP0) ? OP_TAP_FIRST : OP_TAP;
          cmd.tap = TAP_W'(cyc_r - CYC_TAP0);
          pos_nxt = (pos_r == TAP_W'(TAPS - 1)) ? '0 : pos_r + TAP_W'(1);
        end else if (filter_en && cyc_r == CYC_TAP_Y) begin
          cmd.op  = OP_TAP_Y;
          cmd.tap = TAP_W'(TAPS - 1);
          cmd.we  = 1'b1;
        end
        if (cyc_r == cyc_end) begin
          cyc_nxt  = '0;
          pos_nxt  = wp_next;
          base_nxt = base_r + HIST_AW'(TAPS);
          ch_nxt   = ch_r + CH_W'(1);
          if (ch_r == CH_W'(CHANNELS - 1)) begin
            state_nxt = ST_DONE;
          end
        end else begin
          cyc_nxt = cyc_r + CYC_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (filter_en) begin
            wp_nxt = wp_next;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      ch_r        <= '0;
      cyc_r       <= '0;
      base_r      <= '0;
      pos_r       <= '0;
      wp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      ch_r        <= ch_nxt;
      cyc_r       <= cyc_nxt;
      base_r      <= base_nxt;
      pos_r       <= pos_nxt;
      wp_r        <= wp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `UPMIX_ASSERT(a_ldout_sets_valid, cmd.ld_out |=> out_valid_r, "output load lost")
  `UPMIX_ASSERT(a_wp_moves_on_handoff, !cmd.ld_out |=> $stable(wp_r), "write position moved")
  `UPMIX_ASSERT(a_accept_starts_run,
    cmd.ld_in |=> (state_r == ST_RUN && ch_r == '0 && cyc_r == '0), "bad item start")
  `UPMIX_ASSERT(a_run_write_only_newest,
    (state_r == ST_RUN && cmd.we) |-> (cmd.op == OP_TAP_Y && filter_en), "stray history write")

endmodule

@@ hdl/upmix_dp.sv @@
// Datapath: shared multiplier, mix and FIR accumulators, history RAM, result registers.
module upmix_dp
  import upmix_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  upmix_cmd_t                    cmd,
  input  logic signed [SAMPLE_BITS-1:0] in_left,
  input  logic signed [SAMPLE_BITS-1:0] in_right,
  input  gain_bank_t                    gains,
  input  logic                          filter_en,
  output chan_vec_t                     out_data
);

  logic signed [SAMPLE_BITS-1:0]  left_r, right_r;
  logic [OP_W-1:0]                op_d1_r, op_d2_r, op_d3_r;
  logic [TAP_W-1:0]               tap_d1_r;
  logic signed [PROD_BITS-1:0]    prod_r;
  logic signed [MIX_ACC_BITS-1:0] mix_acc_r;
  logic signed [FIR_ACC_BITS-1:0] fir_acc_r;
  logic [SAMPLE_BITS-1:0]         y_r;
  chan_vec_t                      res_r, out_r;

  logic [SAMPLE_BITS-1:0]         hist_rd;
  logic [REG_W-1:0]               gain_w;
  logic signed [SAMPLE_BITS-1:0]  mul_a, mul_b;
  logic signed [PROD_BITS-1:0]    product;
  logic signed [MIX_ACC_BITS-1:0] mix_sh;
  logic signed [FIR_ACC_BITS-1:0] fir_sh;
  logic [SAMPLE_BITS-1:0]         mix_y, fir_y;

  upmix_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.we),
    .waddr (cmd.waddr),
    .wdata (cmd.wr_zero ? '0 : y_r),
    .raddr (cmd.raddr),
    .rdata (hist_rd)
  );

  assign gain_w = gains[cmd.ch];

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op_d1_r)
      OP_MIX_L: begin
        mul_a = left_r;
        mul_b = SAMPLE_BITS'($signed(gain_w[GAIN_BITS-1:0]));
      end
      OP_MIX_R: begin
        mul_a = right_r;
        mul_b = SAMPLE_BITS'($signed(gain_w[2*GAIN_BITS-1:GAIN_BITS]));
      end
      OP_TAP_FIRST, OP_TAP: begin
        mul_a = $signed(hist_rd);
        mul_b = coef(TAP_W'(TAPS - 1) - tap_d1_r);
      end
      OP_TAP_Y: begin
        mul_a = $signed(y_r);
        mul_b = coef(TAP_W'(TAPS - 1) - tap_d1_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign product = mul_a * mul_b;
  assign mix_sh  = mix_acc_r >>> GAIN_FRAC;
  assign fir_sh  = fir_acc_r >>> COEF_FRAC;
  assign mix_y   = sat(FIR_ACC_BITS'(mix_sh));
  assign fir_y   = sat(fir_sh);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_d1_r <= OP_NONE;
      op_d2_r <= OP_NONE;
      op_d3_r <= OP_NONE;
    end else begin
      op_d1_r <= cmd.op;
      op_d2_r <= op_d1_r;
      op_d3_r <= op_d2_r;
    end
  end

  always_ff @(posedge clk) begin
    tap_d1_r <= cmd.tap;
    prod_r   <= product;
    if (cmd.ld_in) begin
      left_r  <= in_left;
      right_r <= in_right;
    end
    case (op_d2_r)
      OP_MIX_L:     mix_acc_r <= $signed(prod_r[MIX_ACC_BITS-1:0]);
      OP_MIX_R:     mix_acc_r <= mix_acc_r + $signed(prod_r[MIX_ACC_BITS-1:0]);
      OP_TAP_FIRST: fir_acc_r <= FIR_ACC_BITS'(prod_r);
      OP_TAP:       fir_acc_r <= fir_acc_r + FIR_ACC_BITS'(prod_r);
      OP_TAP_Y:     fir_acc_r <= fir_acc_r + FIR_ACC_BITS'(prod_r);
      default: begin
      end
    endcase
    if (op_d3_r == OP_MIX_R) begin
      y_r <= mix_y;
      if (!filter_en) begin
        res_r[cmd.ch] <= mix_y;
      end
    end
    if (op_d3_r == OP_TAP_Y) begin
      res_r[cmd.ch] <= fir_y;
    end
    if (cmd.ld_out) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

endmodule

@@ hdl/stereo_to_five_channel_upmix_fir_core.sv @@
// Top level of the stereo to five-channel upmix core with per-channel FIR.
//
// Input channel: in_valid/in_stall carry one stereo frame (in_left_in, in_right_in,
// signed Q1.23). Output channel: out_valid/out_stall carry the five upmixed samples.
// Configuration: APB write/read of five gain registers (0x00..0x10) and
// filter_enable (0x14); write only while the core is idle.
// Each item runs through one shared 24x24 multiplier: per channel two mix
// products, then, with the filter enabled, 31 FIR products: 30 over the history
// RAM (one read port) and one on the new mix result.
// The next item is accepted once the previous results sit in the output register,
// so a stalled receiver holds at most one finished item plus one in progress.
// After reset the 155-entry history RAM is cleared, one entry per cycle, and
// in_stall stays high until the clear is done; registers return to their defaults.
module stereo_to_five_channel_upmix_fir_core
  import upmix_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_left_in,
  input  logic signed [SAMPLE_BITS-1:0] in_right_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_front_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_front_right_out,
  output logic signed [SAMPLE_BITS-1:0] out_surround_left_out,
  output logic signed [SAMPLE_BITS-1:0] out_surround_right_out,
  output logic signed [SAMPLE_BITS-1:0] out_center_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ADDR_W-1:0]             paddr,
  input  logic [REG_W-1:0]              pwdata,
  output logic [REG_W-1:0]              prdata,
  output logic                          pready
);

  gain_bank_t           gains_r, gains_nxt;
  logic                 filter_r, filter_nxt;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 reg_wr;
  upmix_cmd_t           cmd;
  chan_vec_t            dp_out;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign reg_wr  = psel & penable & pwrite;

  always_comb begin
    gains_nxt  = gains_r;
    filter_nxt = filter_r;
    if (reg_wr) begin
      case (reg_idx)
        REG_GAINS_FL, REG_GAINS_FR, REG_GAINS_SL, REG_GAINS_SR, REG_GAINS_C: begin
          gains_nxt[reg_idx] = pwdata;
        end
        REG_FILTER_EN: filter_nxt = pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAINS_FL, REG_GAINS_FR, REG_GAINS_SL, REG_GAINS_SR, REG_GAINS_C: begin
        prdata = gains_r[reg_idx];
      end
      REG_FILTER_EN: prdata = {{(REG_W-1){1'b0}}, filter_r};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gains_r  <= {CHANNELS{GAIN_RESET}};
      filter_r <= 1'b1;
    end else begin
      gains_r  <= gains_nxt;
      filter_r <= filter_nxt;
    end
  end

  upmix_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .filter_en (filter_r),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  upmix_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_left   (in_left_in),
    .in_right  (in_right_in),
    .gains     (gains_r),
    .filter_en (filter_r),
    .out_data  (dp_out)
  );

  assign out_front_left_out     = dp_out[CH_FL];
  assign out_front_right_out    = dp_out[CH_FR];
  assign out_surround_left_out  = dp_out[CH_SL];
  assign out_surround_right_out = dp_out[CH_SR];
  assign out_center_out         = dp_out[CH_C];

endmodule

@@ dv/tb_stereo_to_five_channel_upmix_fir_core.sv @@
// Self-checking testbench for the stereo to five-channel upmix FIR core.
module tb_stereo_to_five_channel_upmix_fir_core;
  import upmix_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                       MIX_SHIFT     = 12;
  localparam int                       FIR_SHIFT     = 23;
  localparam longint                   CLAMP_Q23     = 8380219;
  localparam logic [REG_W-1:0]         GAINS_DEFAULT = 32'h195C0A18;
  localparam logic signed [23:0]       SAMPLE_MAX    = 24'sh7FFFFF;
  localparam logic signed [23:0]       SAMPLE_MIN    = 24'sh800000;
  localparam logic [REG_IDX_W-1:0]     REG_UNMAPPED_0 = 3'd6;
  localparam logic [REG_IDX_W-1:0]     REG_UNMAPPED_1 = 3'd7;
  localparam int                       RAND_PHASES    = 10;
  localparam int                       RAND_PER_PHASE = 153;
  localparam int                       HOLDOFF_CYCLES = 1500;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] l;
    logic signed [SAMPLE_BITS-1:0] r;
  } stereo_frame_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_left_in = '0;
  logic signed [SAMPLE_BITS-1:0] in_right_in = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_front_left_out;
  logic signed [SAMPLE_BITS-1:0] out_front_right_out;
  logic signed [SAMPLE_BITS-1:0] out_surround_left_out;
  logic signed [SAMPLE_BITS-1:0] out_surround_right_out;
  logic signed [SAMPLE_BITS-1:0] out_center_out;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [ADDR_W-1:0]             paddr = '0;
  logic [REG_W-1:0]              pwdata = '0;
  logic [REG_W-1:0]              prdata;
  logic                          pready;

  stereo_frame_t pending_frames [$];
  chan_vec_t     expected_frames [$];
  int            errors = 0;
  int            results_seen = 0;

  // predictor state
  logic [REG_W-1:0] gain_regs [CHANNELS] = '{GAINS_DEFAULT, GAINS_DEFAULT, GAINS_DEFAULT,
                                             GAINS_DEFAULT, GAINS_DEFAULT};
  bit               filt_en = 1'b1;
  longint           fir_hist [CHANNELS][TAPS];
  int               hist_wpos = 0;
  longint           fir_coef [TAPS] = '{
    -2714, 5150, -8252, 11408, -13179, 10860, -22, -25835,
    75265, -158123, 283572, -456275, 670256, -900217, 1090801, 7223215,
    1090801, -900217, 670256, -456275, 283572, -158123, 75265, -25835,
    -22, 10860, -13179, 11408, -8252, 5150, -2714};

  logic [REG_IDX_W-1:0] gain_reg_idx [CHANNELS] = '{REG_GAINS_FL, REG_GAINS_FR, REG_GAINS_SL,
                                                    REG_GAINS_SR, REG_GAINS_C};
  string chan_name [CHANNELS] = '{"front_left", "front_right", "surround_left",
                                  "surround_right", "center"};

  stereo_to_five_channel_upmix_fir_core dut (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (in_valid),
    .in_stall               (in_stall),
    .in_left_in             (in_left_in),
    .in_right_in            (in_right_in),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_front_left_out     (out_front_left_out),
    .out_front_right_out    (out_front_right_out),
    .out_surround_left_out  (out_surround_left_out),
    .out_surround_right_out (out_surround_right_out),
    .out_center_out         (out_center_out),
    .psel                   (psel),
    .penable                (penable),
    .pwrite                 (pwrite),
    .paddr                  (paddr),
    .pwdata                 (pwdata),
    .prdata                 (prdata),
    .pready                 (pready)
  );

  always #1 clk = ~clk;

  function automatic longint clamp_q23(input longint v);
    if (v > CLAMP_Q23) return CLAMP_Q23;
    if (v < -CLAMP_Q23) return -CLAMP_Q23;
    return v;
  endfunction

  // mix, optional FIR per channel; advances the shared history pointer when the filter is on
  function automatic chan_vec_t upmix_frame(input logic signed [SAMPLE_BITS-1:0] l,
                                            input logic signed [SAMPLE_BITS-1:0] r);
    chan_vec_t          res;
    longint             acc;
    longint             y;
    logic signed [15:0] gl;
    logic signed [15:0] gr;
    int                 nxt;
    int                 pos;
    nxt = (hist_wpos + 1) % TAPS;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      gl = gain_regs[ch][15:0];
      gr = gain_regs[ch][31:16];
      acc = longint'(l) * longint'(gl) + longint'(r) * longint'(gr);
      y = clamp_q23(acc >>> MIX_SHIFT);
      if (filt_en) begin
        fir_hist[ch][hist_wpos] = y;
        acc = 0;
        pos = nxt;
        for (int k = 0; k < TAPS; k++) begin
          acc += fir_coef[TAPS-1-k] * fir_hist[ch][pos];
          pos = (pos + 1) % TAPS;
        end
        y = clamp_q23(acc >>> FIR_SHIFT);
      end
      res[ch] = y[SAMPLE_BITS-1:0];
    end
    if (filt_en) hist_wpos = nxt;
    return res;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    logic signed [SAMPLE_BITS-1:0] picks [5] = '{SAMPLE_MAX, SAMPLE_MIN, 24'sd0, 24'sd1, -24'sd1};
    case ($urandom_range(0, 9))
      0:       return picks[$urandom_range(0, 4)];
      1, 2:    return SAMPLE_BITS'($signed($urandom_range(0, 8191)) - 4096);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [REG_W-1:0] rand_gains();
    logic [15:0] halves [4] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h1000};
    logic [15:0] a;
    logic [15:0] b;
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: begin
        a = 16'($signed($urandom_range(0, 16383)) - 8192);
        b = 16'($signed($urandom_range(0, 16383)) - 8192);
        return {b, a};
      end
      2: return GAINS_DEFAULT;
      default: return {halves[$urandom_range(0, 3)], halves[$urandom_range(0, 3)]};
    endcase
  endfunction

  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_GAINS_FL:  gain_regs[CH_FL] = val;
      REG_GAINS_FR:  gain_regs[CH_FR] = val;
      REG_GAINS_SL:  gain_regs[CH_SL] = val;
      REG_GAINS_SR:  gain_regs[CH_SR] = val;
      REG_GAINS_C:   gain_regs[CH_C]  = val;
      REG_FILTER_EN: filt_en = val[0];
      default: ;
    endcase
  endtask

  // sampled between edges so the driver's updates have settled
  task automatic wait_drained();
    while (pending_frames.size() != 0 || in_valid || expected_frames.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic push_frame(input logic signed [SAMPLE_BITS-1:0] l,
                            input logic signed [SAMPLE_BITS-1:0] r);
    pending_frames.push_back({l, r});
  endtask

  // sender: bursts with random gaps, payload held while stalled
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin : drive_frames
    stereo_frame_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_frames.size() != 0) begin
        nxt = pending_frames.pop_front();
        in_left_in  <= nxt.l;
        in_right_in <= nxt.r;
        in_valid    <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(20, 220) : $urandom_range(0, 4);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stall pattern changes mode now and then; one long hold-off
  int stall_mode = 0;
  int mode_left = 0;
  int holdoff_left = 0;
  bit holdoff_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (holdoff_left != 0) begin
      out_stall    <= 1'b1;
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && results_seen >= 40) begin
      out_stall    <= 1'b1;
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(50, 500);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 3) == 0);
        2:       out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ~out_stall;
      endcase
    end
  end

  always @(posedge clk) begin : check_outputs
    chan_vec_t got;
    chan_vec_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_frames.push_back(upmix_frame(in_left_in, in_right_in));
      end
      if (out_valid && !out_stall) begin
        got[CH_FL] = out_front_left_out;
        got[CH_FR] = out_front_right_out;
        got[CH_SL] = out_surround_left_out;
        got[CH_SR] = out_surround_right_out;
        got[CH_C]  = out_center_out;
        results_seen <= results_seen + 1;
        if (expected_frames.size() == 0) begin
          $display("%0t: output item with none expected, actual %0d %0d %0d %0d %0d", $time,
                   $signed(got[CH_FL]), $signed(got[CH_FR]), $signed(got[CH_SL]),
                   $signed(got[CH_SR]), $signed(got[CH_C]));
          errors++;
        end else begin
          want = expected_frames.pop_front();
          for (int ch = 0; ch < CHANNELS; ch++) begin
            if (got[ch] !== want[ch]) begin
              $display("%0t: %s expected %0d actual %0d", $time, chan_name[ch],
                       $signed(want[ch]), $signed(got[ch]));
              errors++;
            end
          end
        end
      end
    end
  end

  initial begin
    int                            n;
    int                            run;
    logic signed [SAMPLE_BITS-1:0] l;
    logic signed [SAMPLE_BITS-1:0] r;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset gains, filter on
    push_frame(24'sd0, 24'sd0);
    push_frame(SAMPLE_MAX, SAMPLE_MAX);
    push_frame(SAMPLE_MIN, SAMPLE_MIN);
    push_frame(SAMPLE_MAX, SAMPLE_MIN);
    push_frame(SAMPLE_MIN, SAMPLE_MAX);
    push_frame(24'sd1, -24'sd1);
    push_frame(-24'sd1, 24'sd1);
    push_frame(SAMPLE_MAX, 24'sd0);
    push_frame(24'sd0, SAMPLE_MIN);
    push_frame(24'sd0, 24'sd0);
    push_frame(24'sd0, 24'sd0);
    push_frame(-24'sd1, -24'sd1);
    wait_drained();

    // extreme gains, filter off via a write with upper junk bits, unmapped writes
    reg_write(REG_GAINS_FL, 32'h7FFF7FFF);
    reg_write(REG_GAINS_FR, 32'h80008000);
    reg_write(REG_GAINS_SL, 32'h80007FFF);
    reg_write(REG_GAINS_SR, 32'h00000000);
    reg_write(REG_GAINS_C,  32'h00001000);
    reg_write(REG_FILTER_EN, 32'hFFFFFFFE);
    reg_write(REG_UNMAPPED_0, 32'hFFFFFFFF);
    reg_write(REG_UNMAPPED_1, 32'h00000000);
    push_frame(SAMPLE_MAX, SAMPLE_MAX);
    push_frame(SAMPLE_MIN, SAMPLE_MIN);
    push_frame(SAMPLE_MAX, SAMPLE_MIN);
    push_frame(SAMPLE_MIN, SAMPLE_MAX);
    push_frame(24'sd1, 24'sd1);
    push_frame(-24'sd1, -24'sd1);
    push_frame(24'sd0, 24'sd0);
    push_frame(24'sd4096, -24'sd4096);
    wait_drained();

    for (int p = 0; p < RAND_PHASES; p++) begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        if (p == 0) reg_write(gain_reg_idx[ch], 32'h7FFF7FFF);
        else if (p == 1) reg_write(gain_reg_idx[ch], 32'h80008000);
        else reg_write(gain_reg_idx[ch], rand_gains());
      end
      reg_write(REG_FILTER_EN, ($urandom() & 32'hFFFFFFFE) | ((p % 3 == 2) ? 32'd0 : 32'd1));
      if ($urandom_range(0, 2) == 0) begin
        reg_write($urandom_range(0, 1) ? REG_UNMAPPED_0 : REG_UNMAPPED_1, $urandom());
      end
      n = 0;
      while (n < RAND_PER_PHASE) begin
        case ($urandom_range(0, 11))
          0: begin
            // steady level long enough to fill the history
            run = $urandom_range(32, 48);
            l = rand_sample();
            r = rand_sample();
            repeat (run) push_frame(l, r);
            n += run;
          end
          1: begin
            // full-swing alternation drives the FIR into clamping
            run = $urandom_range(16, 24);
            l = $urandom_range(0, 1) ? SAMPLE_MAX : rand_sample();
            r = $urandom_range(0, 1) ? SAMPLE_MIN : rand_sample();
            repeat (run) begin
              push_frame(l, r);
              push_frame(~l, ~r);
            end
            n += 2 * run;
          end
          default: begin
            push_frame(rand_sample(), rand_sample());
            n++;
          end
        endcase
      end
      wait_drained();
    end

    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
